>>> rtl/mi4_pkg.sv
`timescale 1ns / 1ps
package mi4_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PADDR_W   = 3;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_LOAD_A,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_DIV_GO,
      ST_DIV_WAIT
   } back_state_type;

   typedef struct packed {
      logic        go;
      logic [30:0] threshold;
   } front_to_back_type;

   // saturating signed 64-bit add
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? S64_MIN : S64_MAX;
      end
      return s;
   endfunction

   // saturating negate
   function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
      return (a == S64_MIN) ? S64_MAX : -a;
   endfunction

   // unsigned magnitude, exact for the most negative value
   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   // n-th member of {0,1,2,3} with excl left out
   function automatic logic [1:0] pick(input logic [1:0] excl, input logic [1:0] n);
      return n + {1'b0, (n >= excl)};
   endfunction

endpackage

>>> rtl/mi4_mul.sv
`timescale 1ns / 1ps
module mi4_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic               done,
   output logic signed [63:0] result
);

   logic               run_ff, run_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic [63:0]        ua_ff, ua_in, ub_ff, ub_in;
   logic [127:0]       acc_ff, acc_in;
   logic [63:0]        prod_ff, prod_in;
   logic [1:0]         shf_ff, shf_in;
   logic               pv_ff, pv_in;
   logic signed [63:0] res_ff, res_in;
   logic [31:0]        ah, bh;
   logic [127:0]       addend;
   logic [63:0]        mag;
   logic               top;

   // one 32x32 partial product per cycle, registered then accumulated
   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      shf_in  = shf_ff;
      pv_in   = 1'b0;
      res_in  = res_ff;
      ah      = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      bh      = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      addend  = {64'd0, prod_ff} << {shf_ff, 5'd0};
      mag     = acc_ff[mi4_pkg::FRAC_BITS +: 64];
      top     = (acc_ff >> (64 + mi4_pkg::FRAC_BITS)) != 128'd0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 3'd0;
         neg_in = a[63] ^ b[63];
         ua_in  = mi4_pkg::mag64(a);
         ub_in  = mi4_pkg::mag64(b);
         acc_in = 128'd0;
      end else if (run_ff) begin
         if (pv_ff) begin
            acc_in = acc_ff + addend;
         end
         if (cnt_ff < 3'd4) begin
            prod_in = ah * bh;
            shf_in  = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            pv_in   = 1'b1;
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd5) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               res_in = (top || mag[63]) ? mi4_pkg::S64_MIN : -$signed(mag);
            end else begin
               res_in = (top || mag[63]) ? mi4_pkg::S64_MAX : $signed(mag);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         pv_ff   <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         pv_ff   <= pv_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      shf_ff  <= shf_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> rtl/mi4_div.sv
`timescale 1ns / 1ps
module mi4_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic               done,
   output logic signed [31:0] result
);

   logic               run_ff, run_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;
   logic [63:0]        ud_ff, ud_in;
   logic [127:0]       dvd_ff, dvd_in;
   logic [63:0]        r_ff, r_in;
   logic [63:0]        q_ff, q_in;
   logic signed [31:0] res_ff, res_in;
   logic [64:0]        rsh;
   logic [63:0]        limit;
   logic [31:0]        qsat;

   // restoring division, one quotient bit per cycle
   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      ud_in   = ud_ff;
      dvd_in  = dvd_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      res_in  = res_ff;
      rsh     = {r_ff, dvd_ff[127]};
      limit   = 64'd0;
      qsat    = 32'd0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 7'd0;
         neg_in = num[63] ^ den[63];
         ovf_in = 1'b0;
         ud_in  = mi4_pkg::mag64(den);
         dvd_in = {64'd0, mi4_pkg::mag64(num)} << mi4_pkg::FRAC_BITS;
         r_in   = 64'd0;
         q_in   = 64'd0;
      end else if (run_ff) begin
         ovf_in = ovf_ff | q_ff[63];
         dvd_in = dvd_ff << 1;
         if (rsh >= {1'b0, ud_ff}) begin
            r_in = 64'(rsh - {1'b0, ud_ff});
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = rsh[63:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            limit   = neg_ff ? 64'h8000_0000 : 64'h7FFF_FFFF;
            qsat    = (ovf_in || q_in > limit) ? limit[31:0] : q_in[31:0];
            res_in  = neg_ff ? -$signed(qsat) : $signed(qsat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      ud_ff  <= ud_in;
      dvd_ff <= dvd_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> rtl/mi4_front.sv
`timescale 1ns / 1ps
module mi4_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [31:0]           req_element,
   output logic                         busy,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mi4_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   input  logic                         back_busy,
   input  logic [3:0]                   rd_addr,
   output logic signed [31:0]           rd_data,
   output mi4_pkg::front_to_back_type   f2b
);

   logic signed [31:0] store_ff [16];
   logic signed [31:0] rd_data_ff;
   logic [3:0]         count_ff, count_in;
   logic               job_ff, job_in;
   logic [30:0]        thr_ff, thr_in;
   logic               accept;
   logic               reg_sel;

   assign busy    = job_ff | back_busy;
   assign accept  = start & ~busy;
   assign reg_sel = (paddr[2] == 1'b0);

   // load counter and one-entry job queue toward the back end
   always_comb begin
      count_in = accept ? count_ff + 4'd1 : count_ff;
      job_in   = job_ff;
      if (accept && count_ff == 4'd15) begin
         job_in = 1'b1;
      end else if (job_ff && !back_busy) begin
         job_in = 1'b0;
      end
      thr_in = thr_ff;
      if (psel && penable && pwrite && reg_sel) begin
         thr_in = pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         job_ff   <= 1'b0;
         thr_ff   <= 31'd1;
      end else begin
         count_ff <= count_in;
         job_ff   <= job_in;
         thr_ff   <= thr_in;
      end
   end

   // element store, read data registered
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[count_ff] <= req_element;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data       = rd_data_ff;
   assign prdata        = reg_sel ? {1'b0, thr_ff} : 32'd0;
   assign pready        = 1'b1;
   assign f2b.go        = job_ff;
   assign f2b.threshold = thr_ff;

endmodule

>>> rtl/mi4_back.sv
`timescale 1ns / 1ps
module mi4_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mi4_pkg::front_to_back_type f2b,
   output logic                       back_busy,
   output logic [3:0]                 rd_addr,
   input  logic signed [31:0]         rd_data,
   output logic                       rsp_valid,
   output logic signed [31:0]         rsp_value,
   output logic [3:0]                 rsp_position,
   output logic                       rsp_last,
   output logic                       rsp_singular
);

   mi4_pkg::back_state_type state_ff, state_in;
   logic [3:0]         ai_ff, ai_in;
   logic [1:0]         tk_ff, tk_in;
   logic [1:0]         ph_ff, ph_in;
   logic [1:0]         jd_ff, jd_in;
   logic               dm_ff, dm_in;
   logic [3:0]         k_ff, k_in;
   logic signed [63:0] opa_ff, opa_in;
   logic signed [63:0] mn_ff, mn_in;
   logic signed [63:0] s_ff, s_in;
   logic signed [63:0] det_ff, det_in;
   logic signed [63:0] adj_ff [16];
   logic               adj_we;
   logic signed [63:0] adj_wd;
   logic [3:0]         adj_ra;
   logic signed [63:0] adj_rd_ff;
   logic               ov_ff, ov_in;
   logic signed [31:0] ovv_ff, ovv_in;
   logic [3:0]         ovp_ff, ovp_in;
   logic               ovl_ff, ovl_in;
   logic               ovs_ff, ovs_in;

   logic [1:0]         ci, rj, r0, r1, r2, ca, cb, ck;
   logic [3:0]         addr_a, addr_b;
   logic signed [63:0] el, opb, snew;
   logic               mul_start, mul_done, div_start, div_done;
   logic signed [63:0] mul_res;
   logic signed [31:0] div_res;

   // row and column picks for the current adjugate term
   always_comb begin
      ci     = ai_ff[3:2];
      rj     = ai_ff[1:0];
      r0     = mi4_pkg::pick(rj, 2'd0);
      r1     = mi4_pkg::pick(rj, 2'd1);
      r2     = mi4_pkg::pick(rj, 2'd2);
      ca     = mi4_pkg::pick(ci, (tk_ff == 2'd0) ? 2'd1 : 2'd0);
      cb     = mi4_pkg::pick(ci, (tk_ff == 2'd2) ? 2'd1 : 2'd2);
      ck     = mi4_pkg::pick(ci, tk_ff);
      addr_a = dm_ff ? {2'b00, jd_ff} :
               (ph_ff == 2'd0) ? {r1, ca} :
               (ph_ff == 2'd1) ? {r1, cb} : {r0, ck};
      addr_b = (ph_ff == 2'd0) ? {r2, cb} : {r2, ca};
      rd_addr = (state_ff == mi4_pkg::ST_ADDR) ? addr_a : addr_b;
      el     = 64'(rd_data);
      opb    = dm_ff ? adj_rd_ff : ((ph_ff == 2'd2) ? mn_ff : el);
   end

   // sequencer: adjugate terms, determinant, check, divisions
   always_comb begin
      state_in  = state_ff;
      ai_in     = ai_ff;
      tk_in     = tk_ff;
      ph_in     = ph_ff;
      jd_in     = jd_ff;
      dm_in     = dm_ff;
      k_in      = k_ff;
      opa_in    = opa_ff;
      mn_in     = mn_ff;
      s_in      = s_ff;
      det_in    = det_ff;
      adj_we    = 1'b0;
      adj_wd    = s_ff;
      ov_in     = 1'b0;
      ovv_in    = ovv_ff;
      ovp_in    = ovp_ff;
      ovl_in    = ovl_ff;
      ovs_in    = ovs_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      snew      = s_ff;
      case (state_ff)
         mi4_pkg::ST_IDLE: begin
            if (f2b.go) begin
               ai_in    = 4'd0;
               tk_in    = 2'd0;
               ph_in    = 2'd0;
               dm_in    = 1'b0;
               state_in = mi4_pkg::ST_ADDR;
            end
         end
         mi4_pkg::ST_ADDR: begin
            state_in = mi4_pkg::ST_LOAD_A;
         end
         mi4_pkg::ST_LOAD_A: begin
            opa_in   = el;
            state_in = mi4_pkg::ST_MUL_GO;
         end
         mi4_pkg::ST_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = mi4_pkg::ST_MUL_WAIT;
         end
         mi4_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = mi4_pkg::ST_ADDR;
               if (dm_ff) begin
                  det_in = mi4_pkg::sat_add(det_ff, mul_res);
                  jd_in  = jd_ff + 2'd1;
                  if (jd_ff == 2'd3) begin
                     state_in = mi4_pkg::ST_CHECK;
                  end
               end else begin
                  case (ph_ff)
                     2'd0: begin
                        mn_in = mul_res;
                        ph_in = 2'd1;
                     end
                     2'd1: begin
                        mn_in = mi4_pkg::sat_add(mn_ff, mi4_pkg::sat_neg(mul_res));
                        ph_in = 2'd2;
                     end
                     default: begin
                        if (tk_ff == 2'd0) begin
                           snew = mul_res;
                        end else if (tk_ff == 2'd1) begin
                           snew = mi4_pkg::sat_add(s_ff, mi4_pkg::sat_neg(mul_res));
                        end else begin
                           snew = mi4_pkg::sat_add(s_ff, mul_res);
                        end
                        s_in  = snew;
                        ph_in = 2'd0;
                        if (tk_ff == 2'd2) begin
                           tk_in  = 2'd0;
                           adj_we = 1'b1;
                           adj_wd = (ci[0] ^ rj[0]) ? mi4_pkg::sat_neg(snew) : snew;
                           ai_in  = ai_ff + 4'd1;
                           if (ai_ff == 4'd15) begin
                              dm_in  = 1'b1;
                              jd_in  = 2'd0;
                              det_in = 64'sd0;
                           end
                        end else begin
                           tk_in = tk_ff + 2'd1;
                        end
                     end
                  endcase
               end
            end
         end
         mi4_pkg::ST_CHECK: begin
            if (det_ff == 64'sd0 ||
                mi4_pkg::mag64(det_ff) < {33'd0, f2b.threshold}) begin
               ov_in    = 1'b1;
               ovv_in   = 32'sd0;
               ovp_in   = 4'd0;
               ovl_in   = 1'b1;
               ovs_in   = 1'b1;
               state_in = mi4_pkg::ST_IDLE;
            end else begin
               k_in     = 4'd0;
               state_in = mi4_pkg::ST_DIV_GO;
            end
         end
         mi4_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = mi4_pkg::ST_DIV_WAIT;
         end
         mi4_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               ov_in  = 1'b1;
               ovv_in = div_res;
               ovp_in = k_ff;
               ovl_in = (k_ff == 4'd15);
               ovs_in = 1'b0;
               k_in   = k_ff + 4'd1;
               state_in = (k_ff == 4'd15) ? mi4_pkg::ST_IDLE : mi4_pkg::ST_DIV_GO;
            end
         end
         default: begin
            state_in = mi4_pkg::ST_IDLE;
         end
      endcase
      // adjugate read address; the read data is registered before its use
      adj_ra = (state_ff == mi4_pkg::ST_CHECK || state_ff == mi4_pkg::ST_DIV_GO ||
                state_ff == mi4_pkg::ST_DIV_WAIT) ? k_in : {jd_ff, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mi4_pkg::ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      ai_ff  <= ai_in;
      tk_ff  <= tk_in;
      ph_ff  <= ph_in;
      jd_ff  <= jd_in;
      dm_ff  <= dm_in;
      k_ff   <= k_in;
      opa_ff <= opa_in;
      mn_ff  <= mn_in;
      s_ff   <= s_in;
      det_ff <= det_in;
      ovv_ff <= ovv_in;
      ovp_ff <= ovp_in;
      ovl_ff <= ovl_in;
      ovs_ff <= ovs_in;
   end

   // adjugate registers, read data registered
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_ff[ai_ff] <= adj_wd;
      end
      adj_rd_ff <= adj_ff[adj_ra];
   end

   mi4_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (opa_ff),
      .b      (opb),
      .done   (mul_done),
      .result (mul_res)
   );

   mi4_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (adj_rd_ff),
      .den    (det_ff),
      .done   (div_done),
      .result (div_res)
   );

   assign back_busy    = (state_ff != mi4_pkg::ST_IDLE);
   assign rsp_valid    = ov_ff;
   assign rsp_value    = ovv_ff;
   assign rsp_position = ovp_ff;
   assign rsp_last     = ovl_ff;
   assign rsp_singular = ovs_ff;

endmodule

>>> rtl/matrix_inverse_4x4_top.sv
`timescale 1ns / 1ps
// channel   | ports                                            | beat when
// ----------+--------------------------------------------------+---------------------------
// request   | start, busy, req_element                         | start high, busy low
// response  | rsp_valid, rsp_value, rsp_position, rsp_last,    | rsp_valid high (one cycle)
//           | rsp_singular                                     |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,    | psel, penable high
//           | pready                                           |
//
// elements load one per cycle while busy is low; the sixteenth raises busy for the
// whole inversion, which runs 148 products through the shared 32x32 multiplier
// and, unless the matrix is singular, 16 divides at one bit per cycle
// results come one per divide; a singular matrix gives its one beat after the check
// synchronous reset clears the counters, sequencer and threshold (to 1)
// the receiver cannot stall: each result beat is shown for exactly one cycle
module matrix_inverse_4x4_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_element,
   output logic                        rsp_valid,
   output logic signed [31:0]          rsp_value,
   output logic [3:0]                  rsp_position,
   output logic                        rsp_last,
   output logic                        rsp_singular,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mi4_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   mi4_pkg::front_to_back_type f2b;
   logic               back_busy;
   logic [3:0]         rd_addr;
   logic signed [31:0] rd_data;

   // loader, store and register file
   mi4_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_element (req_element),
      .busy        (busy),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .back_busy   (back_busy),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .f2b         (f2b)
   );

   // inversion sequencer
   mi4_back u_back (
      .clock        (clock),
      .reset        (reset),
      .f2b          (f2b),
      .back_busy    (back_busy),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last),
      .rsp_singular (rsp_singular)
   );

endmodule

>>> rtl/mi4_checker.sv
`timescale 1ns / 1ps
module mi4_checker (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_value,
   input logic [3:0]         rsp_position,
   input logic               rsp_last,
   input logic               rsp_singular
);

   // a result beat only comes out of a running inversion
   a_beat_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a running inversion");

   // singular beat is alone, last, and zero
   a_singular_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_last && rsp_value == 32'sd0 &&
                                   rsp_position == 4'd0)
      else $error("malformed singular beat");

   // last beat sits at position fifteen unless singular
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_singular |-> rsp_position == 4'd15)
      else $error("last beat at wrong position");

   // nothing follows the last beat right away
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("beat right after last");

endmodule

bind matrix_inverse_4x4_top mi4_checker u_mi4_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_value    (rsp_value),
   .rsp_position (rsp_position),
   .rsp_last     (rsp_last),
   .rsp_singular (rsp_singular)
);
